@@ design/sle_pkg.sv @@
// Shared types and constants for the sorted list engine.
// Used by sle_ctrl, sle_datapath and sorted_list_engine; depends on nothing.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int KIND_W      = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 7;
  localparam int OUT_VALUE_W = 32;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CHECK,
    ST_FOUND,
    ST_INS_RD,
    ST_INS_WR,
    ST_REM_RD,
    ST_REM_WR,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_INS,
    RA_REM,
    RA_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_MV,
    WA_MV_M1,
    WA_POS
  } wa_sel_t;

  typedef enum logic {
    WD_RDATA,
    WD_VALUE
  } wd_sel_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    ptr_inc;
    logic    pos_capture;
    logic    hit_check;
    logic    mv_load_ins;
    logic    mv_load_rem;
    logic    mv_inc;
    logic    mv_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    set_status;
    status_t status;
    logic    set_pos;
    logic    set_rv;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  ptr_end;
    logic  data_ge;
    logic  hit;
    logic  ins_done;
    logic  rem_done;
    logic  idx_bad;
    logic  out_busy;
  } sts_t;

endpackage

@@ design/sorted_list_engine.sv @@
// Sorted list engine. Clear, unused kinds, a full insert and a read beyond count go from decode
// straight to the result; a read waits on the memory; a lookup, remove or insert first scans
// to p, the first entry not below the value (n if none), then an insert shifts entries up and
// a hit remove shifts them down. One request at a time: in_tready returns the cycle after the
// result loads, and a result waits in its state while an earlier one waits on out_tready.
// Reset (rst_n low, synchronous) empties list and output.
`timescale 1ns / 1ps

module sorted_list_engine #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sle_pkg::IN_TDATA_W-1:0]  in_tdata,  // value[31:0], index[37:32], zero pad
  input  logic [sle_pkg::KIND_W-1:0]      in_tuser,  // kind[2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sle_pkg::OUT_TDATA_W-1:0] out_tdata  // status[1:0], position[8:2],
                                                     // read_value[40:9], count[47:41]
);

  sle_pkg::cmd_t cmd;
  sle_pkg::sts_t sts;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_kind   (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ design/sle_ctrl.sv @@
// Controller state machine of the sorted list engine.
// Drives datapath commands from datapath status; uses sle_pkg.
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sle_pkg::sts_t sts,
  output sle_pkg::cmd_t cmd
);

  sle_pkg::state_t state_r;
  sle_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sle_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sle_pkg::ST_DECODE;
        end
      end
      sle_pkg::ST_DECODE: begin
        unique case (sts.kind) inside
          sle_pkg::KIND_INSERT: begin
            state_nxt = sts.full ? sle_pkg::ST_RESULT : sle_pkg::ST_SCAN;
          end
          sle_pkg::KIND_REMOVE, sle_pkg::KIND_LOOKUP: begin
            state_nxt = sle_pkg::ST_SCAN;
          end
          sle_pkg::KIND_READ: begin
            state_nxt = sts.idx_bad ? sle_pkg::ST_RESULT : sle_pkg::ST_READ_WAIT;
          end
          default: begin
            state_nxt = sle_pkg::ST_RESULT;
          end
        endcase
      end
      sle_pkg::ST_SCAN: begin
        state_nxt = sts.ptr_end ? sle_pkg::ST_FOUND : sle_pkg::ST_CHECK;
      end
      sle_pkg::ST_CHECK: begin
        state_nxt = sts.data_ge ? sle_pkg::ST_FOUND : sle_pkg::ST_SCAN;
      end
      sle_pkg::ST_FOUND: begin
        if (sts.kind == sle_pkg::KIND_INSERT) begin
          state_nxt = sle_pkg::ST_INS_RD;
        end else if (sts.kind == sle_pkg::KIND_REMOVE && sts.hit) begin
          state_nxt = sle_pkg::ST_REM_RD;
        end else begin
          state_nxt = sle_pkg::ST_RESULT;
        end
      end
      sle_pkg::ST_INS_RD: begin
        state_nxt = sts.ins_done ? sle_pkg::ST_RESULT : sle_pkg::ST_INS_WR;
      end
      sle_pkg::ST_INS_WR: begin
        state_nxt = sle_pkg::ST_INS_RD;
      end
      sle_pkg::ST_REM_RD: begin
        state_nxt = sts.rem_done ? sle_pkg::ST_RESULT : sle_pkg::ST_REM_WR;
      end
      sle_pkg::ST_REM_WR: begin
        state_nxt = sle_pkg::ST_REM_RD;
      end
      sle_pkg::ST_READ_WAIT: begin
        state_nxt = sle_pkg::ST_RESULT;
      end
      sle_pkg::ST_RESULT: begin
        if (!sts.out_busy) begin
          state_nxt = sle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = sle_pkg::RA_PTR;
    cmd.wa_sel = sle_pkg::WA_MV;
    cmd.wd_sel = sle_pkg::WD_RDATA;
    cmd.status = sle_pkg::STS_OK;
    in_ready   = 1'b0;
    unique case (state_r)
      sle_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sle_pkg::ST_DECODE: begin
        unique case (sts.kind) inside
          sle_pkg::KIND_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::STS_FULL;
            end
          end
          sle_pkg::KIND_READ: begin
            if (sts.idx_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::STS_BAD_INDEX;
            end else begin
              cmd.rd_sel = sle_pkg::RA_IDX;
            end
          end
          sle_pkg::KIND_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      sle_pkg::ST_SCAN: begin
        cmd.rd_sel      = sle_pkg::RA_PTR;
        cmd.pos_capture = sts.ptr_end;
      end
      sle_pkg::ST_CHECK: begin
        if (sts.data_ge) begin
          cmd.pos_capture = 1'b1;
          cmd.hit_check   = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      sle_pkg::ST_FOUND: begin
        if (sts.kind == sle_pkg::KIND_INSERT) begin
          cmd.mv_load_ins = 1'b1;
        end else if (sts.hit) begin
          cmd.mv_load_rem = (sts.kind == sle_pkg::KIND_REMOVE);
          cmd.set_pos     = (sts.kind == sle_pkg::KIND_LOOKUP);
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = sle_pkg::STS_NOT_FOUND;
        end
      end
      sle_pkg::ST_INS_RD: begin
        if (sts.ins_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = sle_pkg::WA_POS;
          cmd.wd_sel  = sle_pkg::WD_VALUE;
          cmd.cnt_inc = 1'b1;
          cmd.set_pos = 1'b1;
        end else begin
          cmd.rd_sel = sle_pkg::RA_INS;
        end
      end
      sle_pkg::ST_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = sle_pkg::WA_MV;
        cmd.wd_sel = sle_pkg::WD_RDATA;
        cmd.mv_dec = 1'b1;
      end
      sle_pkg::ST_REM_RD: begin
        if (sts.rem_done) begin
          cmd.cnt_dec = 1'b1;
          cmd.set_pos = 1'b1;
        end else begin
          cmd.rd_sel = sle_pkg::RA_REM;
        end
      end
      sle_pkg::ST_REM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = sle_pkg::WA_MV_M1;
        cmd.wd_sel = sle_pkg::WD_RDATA;
        cmd.mv_inc = 1'b1;
      end
      sle_pkg::ST_READ_WAIT: begin
        cmd.set_rv = 1'b1;
      end
      sle_pkg::ST_RESULT: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/sle_datapath.sv @@
// Datapath of the sorted list engine: entry memory, pointers, count and result register.
// Acts on commands from sle_ctrl; uses sle_pkg.
`timescale 1ns / 1ps

module sle_datapath #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sle_pkg::KIND_W-1:0]          in_kind,
  input  logic [sle_pkg::IN_TDATA_W-1:0]      in_data,
  input  sle_pkg::cmd_t                       cmd,
  output sle_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sle_pkg::OUT_TDATA_W-1:0]     out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int XW = (CW > sle_pkg::INDEX_W) ? CW : sle_pkg::INDEX_W;

  logic signed [VALUE_WIDTH-1:0]         mem_r [DEPTH];
  logic signed [VALUE_WIDTH-1:0]         rd_data_r;
  logic        [AW-1:0]                  rd_addr;
  logic        [AW-1:0]                  wr_addr;
  logic signed [VALUE_WIDTH-1:0]         wr_data;

  sle_pkg::kind_t                        kind_r;
  logic signed [VALUE_WIDTH-1:0]         value_r;
  logic        [sle_pkg::INDEX_W-1:0]    index_r;
  logic        [CW-1:0]                  ptr_r;
  logic        [CW-1:0]                  pos_r;
  logic        [CW-1:0]                  mv_r;
  logic        [CW-1:0]                  mv_m1;
  logic        [CW-1:0]                  cnt_r;
  logic                                  hit_r;
  sle_pkg::status_t                      res_status_r;
  logic        [CW-1:0]                  res_pos_r;
  logic signed [VALUE_WIDTH-1:0]         res_rv_r;
  logic                                  out_valid_r;
  logic        [sle_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic signed [sle_pkg::IN_VALUE_W-1:0] in_value;
  logic        [XW-1:0]                  idx_ext;
  logic        [sle_pkg::OUT_VALUE_W-1:0] rv_out;

  assign in_value = signed'(in_data[sle_pkg::IN_VALUE_W-1:0]);
  assign idx_ext  = XW'(index_r);
  assign mv_m1    = mv_r - 1'b1;
  assign rv_out   = sle_pkg::OUT_VALUE_W'(res_rv_r);

  always_comb begin
    unique case (cmd.rd_sel)
      sle_pkg::RA_PTR: rd_addr = ptr_r[AW-1:0];
      sle_pkg::RA_INS: rd_addr = mv_m1[AW-1:0];
      sle_pkg::RA_REM: rd_addr = mv_r[AW-1:0];
      sle_pkg::RA_IDX: rd_addr = idx_ext[AW-1:0];
      default:         rd_addr = ptr_r[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      sle_pkg::WA_MV:    wr_addr = mv_r[AW-1:0];
      sle_pkg::WA_MV_M1: wr_addr = mv_m1[AW-1:0];
      sle_pkg::WA_POS:   wr_addr = pos_r[AW-1:0];
      default:           wr_addr = mv_r[AW-1:0];
    endcase
    wr_data = (cmd.wd_sel == sle_pkg::WD_VALUE) ? value_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= sle_pkg::kind_t'(in_kind);
      value_r <= VALUE_WIDTH'(in_value);
      index_r <= in_data[sle_pkg::IN_VALUE_W +: sle_pkg::INDEX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      pos_r        <= '0;
      mv_r         <= '0;
      cnt_r        <= '0;
      hit_r        <= 1'b0;
      res_status_r <= sle_pkg::STS_OK;
      res_pos_r    <= '0;
      res_rv_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        ptr_r        <= '0;
        hit_r        <= 1'b0;
        res_status_r <= sle_pkg::STS_OK;
        res_pos_r    <= '0;
        res_rv_r     <= '0;
      end
      if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.pos_capture) begin
        pos_r <= ptr_r;
      end
      if (cmd.hit_check) begin
        hit_r <= (rd_data_r == value_r);
      end
      if (cmd.mv_load_ins) begin
        mv_r <= cnt_r;
      end else if (cmd.mv_load_rem) begin
        mv_r <= pos_r + 1'b1;
      end else if (cmd.mv_inc) begin
        mv_r <= mv_r + 1'b1;
      end else if (cmd.mv_dec) begin
        mv_r <= mv_m1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (cmd.set_pos) begin
        res_pos_r <= pos_r;
      end
      if (cmd.set_rv) begin
        res_rv_r <= rd_data_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {sle_pkg::COUNT_W'(cnt_r), rv_out,
                     sle_pkg::POS_W'(res_pos_r), res_status_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.kind     = kind_r;
    sts.full     = (cnt_r == CW'(DEPTH));
    sts.ptr_end  = (ptr_r == cnt_r);
    sts.data_ge  = (rd_data_r >= value_r);
    sts.hit      = hit_r;
    sts.ins_done = (mv_r == pos_r);
    sts.rem_done = (mv_r == cnt_r);
    sts.idx_bad  = (idx_ext >= XW'(cnt_r));
    sts.out_busy = out_valid_r && !out_ready;
  end

endmodule
